FILE: hw/rtl/ppm_fg_pkg.sv
// Shared constants and types for the PPM frame generator.
package ppm_fg_pkg;

   localparam int NUM_CHANNELS = 12;
   localparam int CHAN_IDX_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int NEXT_CHAN_W  = $clog2(NUM_CHANNELS + 1);

   localparam int CHAN_STORE_W = 12;
   localparam int COUNT_W      = 24;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;

   localparam logic [CHAN_STORE_W-1:0] CHANNEL_RESET = 12'd1500;
   localparam logic [CHAN_STORE_W-1:0] CHANNEL_MAX   = 12'hFFF;
   localparam logic [COUNT_W-1:0]      COUNT_MAX     = 24'hFF_FFFF;

   localparam logic [7:0]  TICKS_PER_US_RESET    = 8'd200;
   localparam logic [9:0]  PULSE_WIDTH_US_RESET  = 10'd300;
   localparam logic [15:0] FRAME_LENGTH_US_RESET = 16'd22500;
   localparam logic [11:0] MIN_CHANNEL_US_RESET  = 12'd1000;
   localparam logic [11:0] MAX_CHANNEL_US_RESET  = 12'd2000;

   typedef enum logic {
      MODE_TICK  = 1'b0,
      MODE_WRITE = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      CSR_TICKS_PER_US    = 3'd0,
      CSR_PULSE_WIDTH_US  = 3'd1,
      CSR_FRAME_LENGTH_US = 3'd2,
      CSR_MIN_CHANNEL_US  = 3'd3,
      CSR_MAX_CHANNEL_US  = 3'd4
   } csr_index_type;

endpackage

FILE: hw/rtl/ppm_fg_req_if.sv
// Input channel: tick and channel write items.
interface ppm_fg_req_if
   import ppm_fg_pkg::*;
   ;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [3:0]  chan_index;
   logic [15:0] chan_value;

   modport source (output valid, output mode, output chan_index, output chan_value,
                   input ready);
   modport sink   (input valid, input mode, input chan_index, input chan_value,
                   output ready);
endinterface

FILE: hw/rtl/ppm_fg_rsp_if.sv
// Result channel: pin level per tick item.
interface ppm_fg_rsp_if
   import ppm_fg_pkg::*;
   ;
   logic valid;
   logic ready;
   logic pin_level;
   logic frame_start;

   modport source (output valid, output pin_level, output frame_start, input ready);
   modport sink   (input valid, input pin_level, input frame_start, output ready);
endinterface

FILE: hw/rtl/ppm_frame_generator.sv
// PPM frame generator top level: CSRs, channel store, pulse timer, result register.
//
//   channel   dir   handshake        carries
//   req_ch    in    valid/ready      mode, chan_index, chan_value
//   rsp_ch    out   valid/ready      pin_level, frame_start (tick items only)
//   csr_*     in    APB write/read   five timing and clamp registers
//
// One item is taken per clock while the output register can take it; the timer state
// and the one-deep output register both update at the accept edge.
// A new item is taken whenever the output register is empty or being drained.
// Reset loads register defaults, all channels to 1500 us, pin low, timer expired.
// Write items update the store and return nothing; they do not advance the timer.
module ppm_frame_generator
   import ppm_fg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   ppm_fg_req_if.sink            req_ch,
   ppm_fg_rsp_if.source          rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // ---------------- configuration registers ----------------
   logic [7:0]  ticks_per_us_ff;
   logic [9:0]  pulse_width_us_ff;
   logic [15:0] frame_length_us_ff;
   logic [11:0] min_channel_us_ff;
   logic [11:0] max_channel_us_ff;

   logic          csr_write;
   csr_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_us_ff    <= TICKS_PER_US_RESET;
         pulse_width_us_ff  <= PULSE_WIDTH_US_RESET;
         frame_length_us_ff <= FRAME_LENGTH_US_RESET;
         min_channel_us_ff  <= MIN_CHANNEL_US_RESET;
         max_channel_us_ff  <= MAX_CHANNEL_US_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TICKS_PER_US:    ticks_per_us_ff    <= csr_pwdata[7:0];
            CSR_PULSE_WIDTH_US:  pulse_width_us_ff  <= csr_pwdata[9:0];
            CSR_FRAME_LENGTH_US: frame_length_us_ff <= csr_pwdata[15:0];
            CSR_MIN_CHANNEL_US:  min_channel_us_ff  <= csr_pwdata[11:0];
            CSR_MAX_CHANNEL_US:  max_channel_us_ff  <= csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_TICKS_PER_US:    csr_prdata = {24'd0, ticks_per_us_ff};
         CSR_PULSE_WIDTH_US:  csr_prdata = {22'd0, pulse_width_us_ff};
         CSR_FRAME_LENGTH_US: csr_prdata = {16'd0, frame_length_us_ff};
         CSR_MIN_CHANNEL_US:  csr_prdata = {20'd0, min_channel_us_ff};
         CSR_MAX_CHANNEL_US:  csr_prdata = {20'd0, max_channel_us_ff};
         default:             csr_prdata = '0;
      endcase
   end

   // ---------------- handshake ----------------
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_pin_ff, rsp_pin_in;
   logic rsp_start_ff, rsp_start_in;
   logic accept, tick, chan_write;

   // output register frees up in the same cycle it is drained
   assign req_ch.ready = ~rsp_valid_ff | rsp_ch.ready;
   assign accept       = req_ch.valid & req_ch.ready;
   assign tick         = accept & (mode_type'(req_ch.mode) == MODE_TICK);
   assign chan_write   = accept & (mode_type'(req_ch.mode) == MODE_WRITE);

   // ---------------- channel store ----------------
   logic [CHAN_STORE_W-1:0] chan_store_ff [NUM_CHANNELS];
   logic [CHAN_STORE_W-1:0] chan_wdata;
   logic                    chan_in_range;

   // values wider than 12 bits saturate
   assign chan_wdata    = (req_ch.chan_value > 16'(CHANNEL_MAX)) ? CHANNEL_MAX
                                                             : req_ch.chan_value[11:0];
   assign chan_in_range = (32'(req_ch.chan_index) < NUM_CHANNELS);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            chan_store_ff[i] <= CHANNEL_RESET;
         end
      end else if (chan_write && chan_in_range) begin
         chan_store_ff[req_ch.chan_index[CHAN_IDX_W-1:0]] <= chan_wdata;
      end
   end

   // ---------------- pulse timer ----------------
   logic                   pin_ff, pin_in;
   logic [NEXT_CHAN_W-1:0] next_chan_ff, next_chan_in;
   logic [COUNT_W-1:0]     countdown_ff, countdown_in;
   logic [COUNT_W-1:0]     elapsed_ff, elapsed_in;

   logic [CHAN_STORE_W-1:0] chan_raw, chan_clamped, gap_us;
   logic [COUNT_W-1:0]      pulse_ticks, frame_ticks, gap_ticks;
   logic [COUNT_W-1:0]      seg_len, elapsed_base;
   logic                    last_chan, start;

   // pulse and frame lengths in ticks; products stay below 2^24 for all register values
   assign pulse_ticks = COUNT_W'(pulse_width_us_ff) * COUNT_W'(ticks_per_us_ff);
   assign frame_ticks = COUNT_W'(frame_length_us_ff) * COUNT_W'(ticks_per_us_ff);

   assign last_chan = (32'(next_chan_ff) >= NUM_CHANNELS);
   assign chan_raw  = last_chan ? CHANNEL_RESET
                                : chan_store_ff[next_chan_ff[CHAN_IDX_W-1:0]];

   // when min and max cross, values above max take max and all others take min
   always_comb begin
      if (chan_raw > max_channel_us_ff) begin
         chan_clamped = max_channel_us_ff;
      end else if (chan_raw < min_channel_us_ff) begin
         chan_clamped = min_channel_us_ff;
      end else begin
         chan_clamped = chan_raw;
      end
   end

   assign gap_us    = (chan_clamped > 12'(pulse_width_us_ff))
                      ? chan_clamped - 12'(pulse_width_us_ff) : '0;
   assign gap_ticks = COUNT_W'(gap_us) * COUNT_W'(ticks_per_us_ff);

   always_comb begin
      pin_in       = pin_ff;
      next_chan_in = next_chan_ff;
      countdown_in = countdown_ff;
      elapsed_in   = elapsed_ff;
      start        = 1'b0;
      elapsed_base = elapsed_ff;
      seg_len      = '0;

      if (tick) begin
         if (countdown_ff == '0) begin
            // segment boundary: toggle and load the next segment
            pin_in = ~pin_ff;
            if (!pin_ff) begin
               // rising edge: separator pulse; frame starts at channel zero
               if (next_chan_ff == '0) begin
                  start        = 1'b1;
                  elapsed_base = '0;
               end
               seg_len = pulse_ticks;
            end else if (last_chan) begin
               // sync gap pads out the frame, floors at zero
               next_chan_in = '0;
               seg_len      = (frame_ticks > elapsed_ff) ? frame_ticks - elapsed_ff : '0;
            end else begin
               next_chan_in = next_chan_ff + 1'b1;
               seg_len      = gap_ticks;
            end
            // a zero-length segment still occupies this tick
            countdown_in = (seg_len != '0) ? seg_len - 1'b1 : '0;
         end else begin
            countdown_in = countdown_ff - 1'b1;
         end
         elapsed_in = (elapsed_base != COUNT_MAX) ? elapsed_base + 1'b1 : COUNT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pin_ff       <= 1'b0;
         next_chan_ff <= '0;
         countdown_ff <= '0;
         elapsed_ff   <= '0;
      end else begin
         pin_ff       <= pin_in;
         next_chan_ff <= next_chan_in;
         countdown_ff <= countdown_in;
         elapsed_ff   <= elapsed_in;
      end
   end

   // ---------------- result register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      rsp_pin_in   = rsp_pin_ff;
      rsp_start_in = rsp_start_ff;
      if (tick) begin
         rsp_valid_in = 1'b1;
         rsp_pin_in   = pin_in;
         rsp_start_in = start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_pin_ff   <= rsp_pin_in;
      rsp_start_ff <= rsp_start_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.pin_level   = rsp_pin_ff;
   assign rsp_ch.frame_start = rsp_start_ff;

endmodule
